// ----- src/lst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package lst_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_MIN    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_DEL,
    S_MIN,
    S_RESULT
  } state_t;

  localparam int unsigned POS_W = 9;
  localparam int unsigned LEN_W = 9;
  localparam int unsigned VAL_W = 32;

  localparam logic signed [VAL_W-1:0] MIN_START = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] DEL_FAIL  = 32'shFFFF_FFFF;
  localparam logic signed [VAL_W-1:0] ZERO_VAL  = 32'sh0000_0000;

endpackage

// ----- src/indexed_list_store.sv -----
`timescale 1ns / 1ps
// Sequencing: append, insert at the tail and every rejected request go from accept straight
//   to the result state; other inserts walk from the tail down to the position, delete from
//   the position to the tail, min over the whole list. One request at a time, set by the
//   single read and write port of the element memory walked one entry per cycle.
// Reset: synchronous, active low; clears the length and the sequencer, element
//   memory keeps its contents and is read only below the current length.
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed values with append, insert, delete and minimum.
// ----------------------------------------------------------------------------
module indexed_list_store
  import lst_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic [LEN_W-1:0]        out_length
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata;

  lst_ctrl #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_length       (out_length),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  lst_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- src/lst_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_mem
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lst_mem
  import lst_pkg::*;
#(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic                    re,
  input  logic [ADDR_W-1:0]       raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/lst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_ctrl
// Request sequencer: checks, element walk over the memory, result register.
// ----------------------------------------------------------------------------
module lst_ctrl
  import lst_pkg::*;
#(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned ADDR_W   = 8,
  parameter int unsigned CNT_W    = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic [LEN_W-1:0]        out_length,
  output logic                    mem_we,
  output logic [ADDR_W-1:0]       mem_waddr,
  output logic signed [VAL_W-1:0] mem_wdata,
  output logic                    mem_re,
  output logic [ADDR_W-1:0]       mem_raddr,
  input  logic signed [VAL_W-1:0] mem_rdata
);

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t                  state_r,      state_nxt;
  logic [CNT_W-1:0]        count_r,      count_nxt;
  logic                    out_valid_r,  out_valid_nxt;
  logic [ADDR_W-1:0]       idx_r,        idx_nxt;
  logic [ADDR_W-1:0]       pos_r,        pos_nxt;
  logic signed [VAL_W-1:0] val_r,        val_nxt;
  logic signed [VAL_W-1:0] best_r,       best_nxt;
  logic                    first_r,      first_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic signed [VAL_W-1:0] res_value_r,  res_value_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r,  out_value_nxt;
  logic [LEN_W-1:0]        out_len_r,    out_len_nxt;

  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic                    full;
  logic                    empty;
  logic                    last;
  logic signed [VAL_W-1:0] best_new;

  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign last     = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign best_new = (mem_rdata < best_r) ? mem_rdata : best_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    best_nxt       = best_r;
    first_nxt      = first_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_len_nxt    = out_len_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = ZERO_VAL;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_operation))
            OP_APPEND: begin
              state_nxt     = S_RESULT;
              res_value_nxt = ZERO_VAL;
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = ADDR_W'(count_r);
                mem_wdata      = in_value;
                count_nxt      = count_r + CNT_W'(1);
                res_status_nxt = ST_OK;
              end
            end
            OP_INSERT: begin
              res_value_nxt = ZERO_VAL;
              if (pos_ext > cnt_ext) begin
                res_status_nxt = ST_INDEX;
                state_nxt      = S_RESULT;
              end else if (full) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RESULT;
              end else if (pos_ext == cnt_ext) begin
                mem_we         = 1'b1;
                mem_waddr      = ADDR_W'(count_r);
                mem_wdata      = in_value;
                count_nxt      = count_r + CNT_W'(1);
                res_status_nxt = ST_OK;
                state_nxt      = S_RESULT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(count_r - CNT_W'(1));
                idx_nxt   = ADDR_W'(count_r - CNT_W'(1));
                pos_nxt   = ADDR_W'(pos_ext);
                val_nxt   = in_value;
                state_nxt = S_INS;
              end
            end
            OP_DELETE: begin
              res_value_nxt = DEL_FAIL;
              if (empty) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESULT;
              end else if (pos_ext >= cnt_ext) begin
                res_status_nxt = ST_INDEX;
                state_nxt      = S_RESULT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(pos_ext);
                idx_nxt   = ADDR_W'(pos_ext);
                first_nxt = 1'b1;
                state_nxt = S_DEL;
              end
            end
            OP_MIN: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
                res_value_nxt  = ZERO_VAL;
                state_nxt      = S_RESULT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = '0;
                best_nxt  = MIN_START;
                state_nxt = S_MIN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + ADDR_W'(1);
        mem_wdata = mem_rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_INS_LAST;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - ADDR_W'(1);
          idx_nxt   = idx_r - ADDR_W'(1);
        end
      end
      S_INS_LAST: begin
        mem_we         = 1'b1;
        mem_waddr      = pos_r;
        mem_wdata      = val_r;
        count_nxt      = count_r + CNT_W'(1);
        res_status_nxt = ST_OK;
        state_nxt      = S_RESULT;
      end
      S_DEL: begin
        if (first_r) begin
          res_value_nxt = mem_rdata;
          first_nxt     = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r - ADDR_W'(1);
          mem_wdata = mem_rdata;
        end
        if (last) begin
          count_nxt      = count_r - CNT_W'(1);
          res_status_nxt = ST_OK;
          state_nxt      = S_RESULT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + ADDR_W'(1);
          idx_nxt   = idx_r + ADDR_W'(1);
        end
      end
      S_MIN: begin
        best_nxt = best_new;
        if (last) begin
          res_value_nxt  = best_new;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESULT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + ADDR_W'(1);
          idx_nxt   = idx_r + ADDR_W'(1);
        end
      end
      S_RESULT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_len_nxt    = LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    best_r       <= best_nxt;
    first_r      <= first_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_length       = out_len_r;

endmodule

// ----- sim/list_store_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_store_checker
// Watches both channels of the indexed list store. It keeps its own copy of
// the list, works out the status, value and length that each accepted
// request must return, and compares every accepted result with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module list_store_checker
  import lst_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [1:0]              out_status,
  input  logic signed [VAL_W-1:0] out_result_value,
  input  logic [LEN_W-1:0]        out_length,
  output int unsigned             mismatches,
  output int unsigned             pending
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  logic signed [VAL_W-1:0] held [CAPACITY];
  int unsigned             held_len;
  list_result_t            expected_results [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: ERROR %s", $time, what);
    mismatches++;
  endtask

  function automatic list_result_t apply_request(input op_t op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t            r;
    logic signed [VAL_W-1:0] lowest;
    int                      i;
    r.status = ST_OK;
    r.value  = ZERO_VAL;
    case (op)
      OP_APPEND: begin
        if (held_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held[IDX_W'(held_len)] = val;
          held_len++;
        end
      end
      OP_INSERT: begin
        if (pos > held_len) begin
          r.status = ST_INDEX;
        end else if (held_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = int'(held_len); i > int'(pos); i--) held[IDX_W'(i)] = held[IDX_W'(i-1)];
          held[IDX_W'(pos)] = val;
          held_len++;
        end
      end
      OP_DELETE: begin
        if (held_len == 0) begin
          r.status = ST_EMPTY;
          r.value  = DEL_FAIL;
        end else if (pos >= held_len) begin
          r.status = ST_INDEX;
          r.value  = DEL_FAIL;
        end else begin
          r.value = held[IDX_W'(pos)];
          for (i = int'(pos); i + 1 < int'(held_len); i++) held[IDX_W'(i)] = held[IDX_W'(i+1)];
          held_len--;
        end
      end
      default: begin
        if (held_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lowest = MIN_START;
          for (i = 0; i < int'(held_len); i++) begin
            if (held[IDX_W'(i)] < lowest) lowest = held[IDX_W'(i)];
          end
          r.value = lowest;
        end
      end
    endcase
    r.length = LEN_W'(held_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      held_len = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request(op_t'(in_operation), in_position, in_value));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status: expected %0d, got %0d",
                                      want.status, out_status));
          if (out_result_value !== want.value)
            report_mismatch($sformatf("result_value: expected %0d, got %0d",
                                      want.value, out_result_value));
          if (out_length !== want.length)
            report_mismatch($sformatf("length: expected %0d, got %0d",
                                      want.length, out_length));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Exercises the indexed list store with a directed opening covering empty,
// out-of-range and extreme-value requests, then phases of random requests
// biased toward growing, shrinking or mixed traffic, including one fill to
// capacity. Both sides idle at random, and the receiver holds off twice for
// a long stretch so the store backs up. Mismatches or an idle timeout fail.
// ----------------------------------------------------------------------------
module tb;
  import lst_pkg::*;

  localparam int unsigned      CAPACITY     = 256;
  localparam int unsigned      TARGET_ITEMS = 1300;
  localparam int unsigned      IDLE_LIMIT   = 4000;
  localparam int unsigned      HOLD_CYCLES  = 400;
  localparam logic [POS_W-1:0] POS_TOP      = '1;

  typedef enum int {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIXED
  } mix_t;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_operation = OP_APPEND;
  logic [POS_W-1:0]        in_position  = '0;
  logic signed [VAL_W-1:0] in_value     = '0;
  logic                    out_valid;
  logic                    out_stall    = 1'b1;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_result_value;
  logic [LEN_W-1:0]        out_length;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned list_len;
  int unsigned items_sent;
  int unsigned results_taken;
  int unsigned idle_cycles;
  bit          calm;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  indexed_list_store #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_value(out_result_value),
    .out_length      (out_length)
  );

  list_store_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_value(out_result_value),
    .out_length      (out_length),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  task automatic send_request(input op_t op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    items_sent++;
    // track length only to steer positions
    case (op)
      OP_APPEND: if (list_len < CAPACITY) list_len++;
      OP_INSERT: if (pos <= list_len && list_len < CAPACITY) list_len++;
      OP_DELETE: if (pos < list_len) list_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MIN_START;
      1:       return {1'b1, {(VAL_W-1){1'b0}}};
      2:       return '1;
      3:       return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input op_t op);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return POS_W'($urandom_range(0, POS_TOP));
    if (roll < 20) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return POS_W'(list_len);
        default: return POS_W'(list_len + 1);
      endcase
    end
    if (op == OP_INSERT) return POS_W'($urandom_range(0, list_len));
    if (op == OP_DELETE && list_len != 0) return POS_W'($urandom_range(0, list_len - 1));
    return POS_W'($urandom_range(0, POS_TOP));
  endfunction

  function automatic op_t pick_operation(input mix_t mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MODE_GROW:
        return roll < 45 ? OP_APPEND : roll < 80 ? OP_INSERT : roll < 90 ? OP_DELETE : OP_MIN;
      MODE_SHRINK:
        return roll < 10 ? OP_APPEND : roll < 25 ? OP_INSERT : roll < 85 ? OP_DELETE : OP_MIN;
      default:
        return op_t'(roll % 4);
    endcase
  endfunction

  initial begin
    mix_t        mix;
    int unsigned span;
    bit          filled;
    op_t         op;
    filled = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_MIN, '0, pick_value());
    send_request(OP_DELETE, '0, pick_value());
    send_request(OP_DELETE, POS_TOP, pick_value());
    send_request(OP_INSERT, 1, pick_value());
    send_request(OP_INSERT, 0, 5);
    send_request(OP_APPEND, POS_TOP, MIN_START);
    send_request(OP_APPEND, 0, {1'b1, {(VAL_W-1){1'b0}}});
    send_request(OP_APPEND, 0, '1);
    send_request(OP_APPEND, 0, ZERO_VAL);
    send_request(OP_INSERT, POS_W'(list_len), 32'sh1234_5678);
    send_request(OP_INSERT, 2, -7);
    send_request(OP_INSERT, POS_TOP, pick_value());
    send_request(OP_INSERT, POS_W'(list_len + 1), pick_value());
    send_request(OP_MIN, '0, pick_value());
    send_request(OP_DELETE, POS_W'(list_len), pick_value());
    send_request(OP_DELETE, POS_TOP, pick_value());
    send_request(OP_DELETE, 0, pick_value());
    send_request(OP_DELETE, 2, pick_value());
    send_request(OP_DELETE, POS_W'(list_len - 1), pick_value());
    send_request(OP_MIN, '0, pick_value());
    while (list_len != 0)
      send_request(OP_DELETE, POS_W'($urandom_range(0, list_len - 1)), pick_value());
    send_request(OP_APPEND, 0, MIN_START);
    send_request(OP_MIN, 0, pick_value());

    while (items_sent < TARGET_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if (!filled && items_sent >= 400) begin
        filled = 1'b1;
        while (list_len < CAPACITY)
          send_request(OP_APPEND, POS_W'($urandom_range(0, POS_TOP)), pick_value());
        send_request(OP_APPEND, 0, pick_value());
        send_request(OP_INSERT, 0, pick_value());
        send_request(OP_INSERT, POS_W'(CAPACITY), pick_value());
        send_request(OP_INSERT, POS_W'(CAPACITY + 1), pick_value());
        send_request(OP_INSERT, POS_TOP, pick_value());
        send_request(OP_DELETE, POS_W'(CAPACITY), pick_value());
        send_request(OP_MIN, POS_TOP, pick_value());
        send_request(OP_DELETE, POS_W'(CAPACITY - 1), pick_value());
        send_request(OP_INSERT, POS_W'(CAPACITY - 1), pick_value());
        send_request(OP_DELETE, 0, pick_value());
      end
      mix  = mix_t'($urandom_range(0, 2));
      span = $urandom_range(20, 80);
      repeat (span) begin
        op = pick_operation(mix);
        send_request(op, pick_position(op), pick_value());
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 17);
      if (results_taken == 40 || results_taken == 900) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!out_valid);
        end
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ----- files.f -----
src/lst_pkg.sv
src/lst_mem.sv
src/lst_ctrl.sv
src/indexed_list_store.sv
sim/list_store_checker.sv
sim/tb.sv
